/* hdl/ast_pkg.sv */
// Shared types, constants and character-class helpers for the assembler source tokenizer.
// Depends on nothing; all hdl/ files but ast_if.sv refer to this package by scoped names.
package ast_pkg;

  // Characters with a special meaning to the scanner.
  localparam logic [7:0] CHAR_HASH       = 8'h23;
  localparam logic [7:0] CHAR_DOT        = 8'h2E;
  localparam logic [7:0] CHAR_UNDERSCORE = 8'h5F;
  localparam logic [7:0] CHAR_LF         = 8'h0A;
  localparam logic [7:0] CHAR_SPACE      = 8'h20;
  localparam logic [7:0] CHAR_TAB        = 8'h09;
  localparam logic [7:0] CHAR_CR         = 8'h0D;

  // Line counter and output fields saturate at this value.
  localparam logic [15:0] CAP16 = 16'hFFFF;

  // Token kind codes as they appear on the result channel.
  localparam logic [1:0] KIND_WORD   = 2'd0;
  localparam logic [1:0] KIND_DOT    = 2'd1;
  localparam logic [1:0] KIND_NUMBER = 2'd2;
  localparam logic [1:0] KIND_END    = 2'd3;

  // One byte can give at most this many tokens.
  localparam int MAX_RESULTS = 3;

  // Scanner modes, one-hot.
  typedef enum logic [4:0] {
    MODE_BETWEEN = 5'b00001,
    MODE_COMMENT = 5'b00010,
    MODE_NUMBER  = 5'b00100,
    MODE_DOT     = 5'b01000,
    MODE_WORD    = 5'b10000
  } mode_t;

  // One token as it leaves the block.
  typedef struct packed {
    logic [1:0]  token_kind;
    logic [15:0] token_start;
    logic [15:0] token_length;
    logic [15:0] token_line;
    logic        end_cause;
    logic        last_of_run;
  } result_t;

  // All tokens caused by one byte, handed from the scanner to the result queue.
  typedef struct packed {
    logic                        load;
    logic [1:0]                  count;
    result_t [MAX_RESULTS-1:0]   res;
  } bundle_t;

  // Queue status seen by the scanner.
  typedef struct packed {
    logic       can_load;
  } queue_status_t;

  function automatic logic is_digit(input logic [7:0] c);
    return (c >= 8'h30) && (c <= 8'h39);
  endfunction

  function automatic logic is_alpha(input logic [7:0] c);
    return ((c >= 8'h61) && (c <= 8'h7A)) || ((c >= 8'h41) && (c <= 8'h5A));
  endfunction

  function automatic logic is_alnum(input logic [7:0] c);
    return is_digit(c) || is_alpha(c);
  endfunction

  function automatic logic is_blank(input logic [7:0] c);
    return (c == CHAR_SPACE) || ((c >= CHAR_TAB) && (c <= CHAR_CR));
  endfunction

endpackage

/* hdl/ast_if.sv */
// Valid/ready channel interfaces for the tokenizer: source bytes in, tokens out.
// Depends on nothing.
interface ast_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] text_byte;
  logic       final_byte;

  modport source (output valid, output text_byte, output final_byte, input ready);
  modport sink   (input valid, input text_byte, input final_byte, output ready);
endinterface

interface ast_out_if;
  logic        valid;
  logic        ready;
  logic [1:0]  token_kind;
  logic [15:0] token_start;
  logic [15:0] token_length;
  logic [15:0] token_line;
  logic        end_cause;
  logic        last_of_run;

  modport source (output valid, output token_kind, output token_start, output token_length,
                  output token_line, output end_cause, output last_of_run, input ready);
  modport sink   (input valid, input token_kind, input token_start, input token_length,
                  input token_line, input end_cause, input last_of_run, output ready);
endinterface

/* hdl/assembler_source_tokenizer.sv */
// Assembler source tokenizer. Takes one source byte per transfer and gives word, dot
// keyword, number and end-of-stream tokens with offset, length and line. A byte is
// accepted every cycle unless the result register is still busy; a byte that yields k
// tokens keeps the result register busy until all k have left, one per transfer, while
// one further byte waits in the input register. Tokens leave from the result register.
// Once the end token has gone, bytes are still accepted but give nothing until reset.
// Depends on ast_pkg, ast_if, ast_scanner and ast_result_queue.
module assembler_source_tokenizer #(
  parameter int POSITION_BITS = 16
) (
  input  logic      clk,
  input  logic      rst_n,
  ast_in_if.sink    in_bus,
  ast_out_if.source out_bus
);

  ast_pkg::bundle_t       bundle;
  ast_pkg::queue_status_t qstat;

  ast_scanner #(
    .POSITION_BITS(POSITION_BITS)
  ) u_scanner (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_bus (in_bus),
    .qstat  (qstat),
    .bundle (bundle)
  );

  ast_result_queue u_queue (
    .clk     (clk),
    .rst_n   (rst_n),
    .bundle  (bundle),
    .qstat   (qstat),
    .out_bus (out_bus)
  );

  // A bundle is only handed over when the queue can take it.
  a_load_room: assert property (@(posedge clk) disable iff (!rst_n)
    bundle.load |-> qstat.can_load)
    else $error("token bundle loaded while the result queue was busy");

  // The end token is the final one until reset.
  a_end_last: assert property (@(posedge clk) disable iff (!rst_n)
    (out_bus.valid && out_bus.ready && (out_bus.token_kind == ast_pkg::KIND_END))
      |=> !out_bus.valid)
    else $error("token delivered after the end token");

  a_end_flag: assert property (@(posedge clk) disable iff (!rst_n)
    (out_bus.valid && (out_bus.token_kind == ast_pkg::KIND_END))
      |-> (out_bus.last_of_run && (out_bus.token_length == 16'd0)))
    else $error("end token not closing its run");

  a_token_shape: assert property (@(posedge clk) disable iff (!rst_n)
    (out_bus.valid && (out_bus.token_kind != ast_pkg::KIND_END))
      |-> (!out_bus.end_cause && (out_bus.token_length != 16'd0)))
    else $error("malformed token on the result channel");

endmodule

/* hdl/ast_scanner.sv */
// Input register, scanner state and the single-pass step logic of the tokenizer.
// Depends on ast_pkg and ast_in_if.
module ast_scanner #(
  parameter int POSITION_BITS = 16
) (
  input  logic                   clk,
  input  logic                   rst_n,
  ast_in_if.sink                 in_bus,
  input  ast_pkg::queue_status_t qstat,
  output ast_pkg::bundle_t       bundle
);

  localparam int PB = POSITION_BITS;
  localparam int CW = (PB > 16) ? PB : 16;
  localparam logic [PB-1:0] POS_MAX = {PB{1'b1}};

  // Input register.
  logic       item_v_r;
  logic [7:0] byte_r;
  logic       final_r;

  // Scanner state.
  ast_pkg::mode_t mode_r, mode_nxt;
  logic [PB-1:0]  pos_r, pos_nxt;
  logic [15:0]    line_r, line_nxt;
  logic [PB-1:0]  pstart_r, pstart_nxt;
  logic [PB-1:0]  plen_r, plen_nxt;
  logic [15:0]    pline_r, pline_nxt;
  logic           done_r, done_nxt;

  logic           process;
  logic [1:0]     nres;

  // Clamp a position-wide value to the 16-bit output range.
  function automatic logic [15:0] clamp16(input logic [PB-1:0] v);
    logic [CW-1:0] wide;
    wide = CW'(v);
    return (wide > CW'(ast_pkg::CAP16)) ? ast_pkg::CAP16 : wide[15:0];
  endfunction

  function automatic logic [1:0] kind_of(input ast_pkg::mode_t m);
    logic [1:0] k;
    k = ast_pkg::KIND_WORD;
    if (m == ast_pkg::MODE_NUMBER) k = ast_pkg::KIND_NUMBER;
    else if (m == ast_pkg::MODE_DOT) k = ast_pkg::KIND_DOT;
    return k;
  endfunction

  function automatic logic is_token(input ast_pkg::mode_t m);
    return (m == ast_pkg::MODE_NUMBER) || (m == ast_pkg::MODE_DOT) ||
           (m == ast_pkg::MODE_WORD);
  endfunction

  // Step logic: what one byte does to the state and which tokens it gives.
  always_comb begin
    logic                             tok_mode;
    logic                             extend;
    logic                             fresh;
    logic                             stray;
    ast_pkg::mode_t                   mode_mid;
    ast_pkg::result_t [3:0]           cand;
    logic [3:0]                       cand_v;
    logic [1:0]                       n;

    mode_nxt   = mode_r;
    pos_nxt    = pos_r;
    line_nxt   = line_r;
    pstart_nxt = pstart_r;
    plen_nxt   = plen_r;
    pline_nxt  = pline_r;
    done_nxt   = done_r;
    tok_mode   = 1'b0;
    extend     = 1'b0;
    fresh      = 1'b0;
    stray      = 1'b0;
    mode_mid   = mode_r;
    cand       = '0;
    cand_v     = '0;
    n          = 2'd0;
    bundle.res = '0;

    if (!done_r) begin
      unique case (mode_r)
        ast_pkg::MODE_NUMBER: begin
          tok_mode = 1'b1;
          extend   = ast_pkg::is_digit(byte_r);
        end
        ast_pkg::MODE_DOT: begin
          tok_mode = 1'b1;
          extend   = ast_pkg::is_alnum(byte_r);
        end
        ast_pkg::MODE_WORD: begin
          tok_mode = 1'b1;
          extend   = ast_pkg::is_alnum(byte_r) || (byte_r == ast_pkg::CHAR_UNDERSCORE);
        end
        ast_pkg::MODE_COMMENT: begin
          fresh = (byte_r == ast_pkg::CHAR_LF);
        end
        default: begin
          fresh = 1'b1;
        end
      endcase

      // A token either grows or is closed and the byte is looked at afresh.
      if (tok_mode) begin
        if (extend) begin
          if (plen_r != POS_MAX) plen_nxt = plen_r + PB'(1);
        end else begin
          fresh    = 1'b1;
          cand_v[0] = 1'b1;
          cand[0].token_kind   = kind_of(mode_r);
          cand[0].token_start  = clamp16(pstart_r);
          cand[0].token_length = clamp16(plen_r);
          cand[0].token_line   = pline_r;
        end
      end

      // Fresh byte between tokens.
      if (fresh) begin
        mode_mid = ast_pkg::MODE_BETWEEN;
        if (ast_pkg::is_blank(byte_r)) begin
          if ((byte_r == ast_pkg::CHAR_LF) && (line_r != ast_pkg::CAP16))
            line_nxt = line_r + 16'd1;
        end else if (byte_r == ast_pkg::CHAR_HASH) begin
          mode_mid = ast_pkg::MODE_COMMENT;
        end else if (ast_pkg::is_digit(byte_r) || (byte_r == ast_pkg::CHAR_DOT) ||
                     ast_pkg::is_alpha(byte_r)) begin
          if (ast_pkg::is_digit(byte_r)) mode_mid = ast_pkg::MODE_NUMBER;
          else if (byte_r == ast_pkg::CHAR_DOT) mode_mid = ast_pkg::MODE_DOT;
          else mode_mid = ast_pkg::MODE_WORD;
          pstart_nxt = pos_r;
          plen_nxt   = PB'(1);
          pline_nxt  = line_r;
        end else begin
          stray = 1'b1;
        end
      end
      mode_nxt = mode_mid;

      if (stray) begin
        // A stray byte ends the stream at its own offset.
        cand_v[1] = 1'b1;
        cand[1].token_kind  = ast_pkg::KIND_END;
        cand[1].token_start = clamp16(pos_r);
        cand[1].token_line  = line_r;
        cand[1].end_cause   = 1'b1;
        done_nxt = 1'b1;
      end else begin
        if (pos_r != POS_MAX) pos_nxt = pos_r + PB'(1);
        if (final_r) begin
          // End of input flushes the open token, then the end token.
          if (is_token(mode_mid)) begin
            cand_v[2] = 1'b1;
            cand[2].token_kind   = kind_of(mode_mid);
            cand[2].token_start  = clamp16(pstart_nxt);
            cand[2].token_length = clamp16(plen_nxt);
            cand[2].token_line   = pline_nxt;
          end
          cand_v[3] = 1'b1;
          cand[3].token_kind  = ast_pkg::KIND_END;
          cand[3].token_start = clamp16(pos_nxt);
          cand[3].token_line  = line_nxt;
          mode_nxt = ast_pkg::MODE_BETWEEN;
          done_nxt = 1'b1;
        end
      end

      // Pack the tokens in order and mark the last one.
      for (int i = 0; i < 4; i++) begin
        if (cand_v[i] && (n != 2'd3)) begin
          bundle.res[n] = cand[i];
          n = n + 2'd1;
        end
      end
      if (n != 2'd0) bundle.res[n - 2'd1].last_of_run = 1'b1;
    end
    nres = n;

    // The bundle is handed over once the queue has room for it.
    bundle.count = n;
    bundle.load  = item_v_r && qstat.can_load && (n != 2'd0);
  end

  // A byte is consumed once its tokens have somewhere to go.
  assign process      = item_v_r && (qstat.can_load || (nres == 2'd0));
  assign in_bus.ready = !item_v_r || process;

  // Input register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      item_v_r <= 1'b0;
    end else if (in_bus.valid && in_bus.ready) begin
      item_v_r <= 1'b1;
    end else if (process) begin
      item_v_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_bus.valid && in_bus.ready) begin
      byte_r  <= in_bus.text_byte;
      final_r <= in_bus.final_byte;
    end
  end

  // Scanner state advances by one byte each time a byte is consumed.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r   <= ast_pkg::MODE_BETWEEN;
      pos_r    <= '0;
      line_r   <= 16'd1;
      pstart_r <= '0;
      plen_r   <= '0;
      pline_r  <= 16'd1;
      done_r   <= 1'b0;
    end else if (process) begin
      mode_r   <= mode_nxt;
      pos_r    <= pos_nxt;
      line_r   <= line_nxt;
      pstart_r <= pstart_nxt;
      plen_r   <= plen_nxt;
      pline_r  <= pline_nxt;
      done_r   <= done_nxt;
    end
  end

endmodule

/* hdl/ast_result_queue.sv */
// Result register of the tokenizer: holds the up to three tokens of one byte and
// hands them out one transfer at a time. Depends on ast_pkg and ast_out_if.
module ast_result_queue (
  input  logic                   clk,
  input  logic                   rst_n,
  input  ast_pkg::bundle_t       bundle,
  output ast_pkg::queue_status_t qstat,
  ast_out_if.source              out_bus
);

  logic [1:0]                              count_r;
  ast_pkg::result_t [ast_pkg::MAX_RESULTS-1:0] slot_r;
  logic                                    take;

  assign take           = out_bus.valid && out_bus.ready;
  assign qstat.can_load = (count_r == 2'd0) || ((count_r == 2'd1) && out_bus.ready);

  // The head slot drives the channel.
  assign out_bus.valid        = (count_r != 2'd0);
  assign out_bus.token_kind   = slot_r[0].token_kind;
  assign out_bus.token_start  = slot_r[0].token_start;
  assign out_bus.token_length = slot_r[0].token_length;
  assign out_bus.token_line   = slot_r[0].token_line;
  assign out_bus.end_cause    = slot_r[0].end_cause;
  assign out_bus.last_of_run  = slot_r[0].last_of_run;

  // Count of tokens still waiting.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= 2'd0;
    end else if (bundle.load) begin
      count_r <= bundle.count;
    end else if (take) begin
      count_r <= count_r - 2'd1;
    end
  end

  // A new bundle replaces the slots; otherwise a transfer shifts them forward.
  always_ff @(posedge clk) begin
    if (bundle.load) begin
      slot_r <= bundle.res;
    end else if (take) begin
      slot_r[0] <= slot_r[1];
      slot_r[1] <= slot_r[2];
    end
  end

endmodule

/* tb/sv/tb.sv */
// Self-checking testbench for assembler_source_tokenizer: one source stream is fed byte by
// byte, each token is predicted from the bytes transferred and compared field by field.
// Depends on ast_pkg, ast_if and the tokenizer RTL.
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  // Offsets and token lengths stop at 2^16 - 1 with the default position width.
  localparam logic [15:0] POS_LIMIT = 16'hFFFF;

  // The bytes that count as blanks between tokens.
  localparam logic [7:0] BLANK_SET [6] = '{ast_pkg::CHAR_SPACE, ast_pkg::CHAR_TAB,
                                           ast_pkg::CHAR_LF, 8'h0B, 8'h0C,
                                           ast_pkg::CHAR_CR};

  // Predicts the token stream from the bytes accepted and checks each token that leaves.
  class token_scoreboard;
    ast_pkg::mode_t   mode;
    logic [15:0]      next_pos;
    logic [15:0]      line_no;
    logic [15:0]      tok_start;
    logic [15:0]      tok_len;
    logic [15:0]      tok_line;
    bit               ended;
    ast_pkg::result_t expected_tokens[$];
    int               mismatches;

    function new();
      mode       = ast_pkg::MODE_BETWEEN;
      next_pos   = '0;
      line_no    = 16'd1;
      tok_start  = '0;
      tok_len    = '0;
      tok_line   = 16'd1;
      ended      = 1'b0;
      mismatches = 0;
    endfunction

    static function bit digit_char(logic [7:0] c);
      return (c >= "0") && (c <= "9");
    endfunction

    static function bit letter_char(logic [7:0] c);
      return ((c >= "a") && (c <= "z")) || ((c >= "A") && (c <= "Z"));
    endfunction

    static function bit blank_char(logic [7:0] c);
      return (c == ast_pkg::CHAR_SPACE) || ((c >= ast_pkg::CHAR_TAB) && (c <= ast_pkg::CHAR_CR));
    endfunction

    static function ast_pkg::result_t make_token(logic [1:0] kind, logic [15:0] start,
                                                 logic [15:0] len, logic [15:0] line,
                                                 logic cause);
      ast_pkg::result_t t;
      t.token_kind   = kind;
      t.token_start  = start;
      t.token_length = len;
      t.token_line   = line;
      t.end_cause    = cause;
      t.last_of_run  = 1'b0;
      return t;
    endfunction

    function void open_token(ast_pkg::mode_t m);
      mode      = m;
      tok_start = next_pos;
      tok_len   = 16'd1;
      tok_line  = line_no;
    endfunction

    // The token under construction, typed by the current mode.
    function ast_pkg::result_t held_token();
      logic [1:0] kind;
      kind = ast_pkg::KIND_WORD;
      if (mode == ast_pkg::MODE_NUMBER) kind = ast_pkg::KIND_NUMBER;
      else if (mode == ast_pkg::MODE_DOT) kind = ast_pkg::KIND_DOT;
      return make_token(kind, tok_start, tok_len, tok_line, 1'b0);
    endfunction

    // Advances the scanner by one accepted byte and queues the tokens it yields.
    function void note_byte(logic [7:0] c, logic fin);
      ast_pkg::result_t run [ast_pkg::MAX_RESULTS];
      int      n;
      bit      stray;
      bit      settled;
      bit      grows;
      if (ended) return;
      n       = 0;
      stray   = 1'b0;
      settled = 1'b0;
      // A byte that closes a token goes round again as a fresh byte.
      while (!settled) begin
        if (mode == ast_pkg::MODE_COMMENT) begin
          if (c == ast_pkg::CHAR_LF) mode = ast_pkg::MODE_BETWEEN;
          else settled = 1'b1;
        end else if (mode == ast_pkg::MODE_BETWEEN) begin
          settled = 1'b1;
          if (blank_char(c)) begin
            if (c == ast_pkg::CHAR_LF && line_no != ast_pkg::CAP16) line_no++;
          end else if (c == ast_pkg::CHAR_HASH) begin
            mode = ast_pkg::MODE_COMMENT;
          end else if (digit_char(c)) begin
            open_token(ast_pkg::MODE_NUMBER);
          end else if (c == ast_pkg::CHAR_DOT) begin
            open_token(ast_pkg::MODE_DOT);
          end else if (letter_char(c)) begin
            open_token(ast_pkg::MODE_WORD);
          end else begin
            stray = 1'b1;
          end
        end else begin
          case (mode)
            ast_pkg::MODE_NUMBER: grows = digit_char(c);
            ast_pkg::MODE_DOT:    grows = digit_char(c) || letter_char(c);
            default: grows = digit_char(c) || letter_char(c) ||
                             (c == ast_pkg::CHAR_UNDERSCORE);
          endcase
          if (grows) begin
            if (tok_len != POS_LIMIT) tok_len++;
            settled = 1'b1;
          end else begin
            run[n] = held_token();
            n++;
            mode = ast_pkg::MODE_BETWEEN;
          end
        end
      end

      // A stray byte ends the stream at its own offset; otherwise the offset moves on.
      if (stray) begin
        run[n] = make_token(ast_pkg::KIND_END, next_pos, 16'd0, line_no, 1'b1);
        n++;
        ended = 1'b1;
      end else begin
        if (next_pos != POS_LIMIT) next_pos++;
        if (fin) begin
          if (mode == ast_pkg::MODE_NUMBER || mode == ast_pkg::MODE_DOT ||
              mode == ast_pkg::MODE_WORD) begin
            run[n] = held_token();
            n++;
          end
          mode   = ast_pkg::MODE_BETWEEN;
          run[n] = make_token(ast_pkg::KIND_END, next_pos, 16'd0, line_no, 1'b0);
          n++;
          ended  = 1'b1;
        end
      end

      if (n > 0) run[n-1].last_of_run = 1'b1;
      for (int i = 0; i < n; i++) expected_tokens.push_back(run[i]);
    endfunction

    function void complain(string what, ast_pkg::result_t got, ast_pkg::result_t want);
      mismatches++;
      if (mismatches <= 10) begin
        $display("%0t token error, %s: got kind %0d start %0d len %0d line %0d cause %0b last %0b",
                 $time, what, got.token_kind, got.token_start, got.token_length,
                 got.token_line, got.end_cause, got.last_of_run);
        $display("   expected kind %0d start %0d len %0d line %0d cause %0b last %0b",
                 want.token_kind, want.token_start, want.token_length, want.token_line,
                 want.end_cause, want.last_of_run);
      end
    endfunction

    // Compares one transferred token with the oldest prediction.
    function void check_token(ast_pkg::result_t got);
      ast_pkg::result_t want;
      if (expected_tokens.size() == 0) begin
        complain("no token expected", got, '0);
        return;
      end
      want = expected_tokens.pop_front();
      if (got.token_kind !== want.token_kind || got.token_start !== want.token_start ||
          got.token_length !== want.token_length || got.token_line !== want.token_line ||
          got.end_cause !== want.end_cause || got.last_of_run !== want.last_of_run)
        complain("field differs", got, want);
    endfunction

    function int outstanding();
      return expected_tokens.size();
    endfunction
  endclass

  logic clk;
  logic rst_n;

  ast_in_if  in_bus();
  ast_out_if out_bus();

  assembler_source_tokenizer u_top (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_bus  (in_bus),
    .out_bus (out_bus)
  );

  token_scoreboard sb = new();
  int in_gap_max  = 3;
  int out_gap_max = 3;
  int bytes_sent  = 0;

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  function automatic logic [7:0] pick_letter();
    return ($urandom_range(0, 1) ? 8'h41 : 8'h61) + 8'($urandom_range(0, 25));
  endfunction

  function automatic logic [7:0] pick_digit();
    return 8'h30 + 8'($urandom_range(0, 9));
  endfunction

  function automatic logic [7:0] pick_alnum(bit with_underscore);
    int r;
    r = $urandom_range(0, 19);
    if (with_underscore && r == 0) return ast_pkg::CHAR_UNDERSCORE;
    return (r < 6) ? pick_digit() : pick_letter();
  endfunction

  // Offers one byte after a random pause and returns once it has been transferred.
  task automatic push_byte(input logic [7:0] c, input logic fin);
    int gap;
    gap = $urandom_range(0, in_gap_max);
    if (gap > 0) begin
      in_bus.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_bus.valid      <= 1'b1;
    in_bus.text_byte  <= c;
    in_bus.final_byte <= fin;
    @(posedge clk);
    while (!in_bus.ready) @(posedge clk);
    sb.note_byte(c, fin);
    bytes_sent++;
  endtask

  // Token sink: random back-pressure, with calm stretches, and a check per transfer.
  initial begin : token_sink
    int               stall;
    int               taken;
    ast_pkg::result_t got;
    taken = 0;
    out_bus.ready <= 1'b0;
    wait (rst_n === 1'b1);
    forever begin
      if (taken % 16 == 0) out_gap_max = ($urandom_range(0, 2) == 0) ? 0 : 3;
      stall = $urandom_range(0, out_gap_max);
      if (stall > 0) begin
        out_bus.ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_bus.ready <= 1'b1;
      @(posedge clk);
      while (!out_bus.valid) @(posedge clk);
      got.token_kind   = out_bus.token_kind;
      got.token_start  = out_bus.token_start;
      got.token_length = out_bus.token_length;
      got.token_line   = out_bus.token_line;
      got.end_cause    = out_bus.end_cause;
      got.last_of_run  = out_bus.last_of_run;
      sb.check_token(got);
      taken++;
    end
  end

  // Source stream: directed text, random tokens, then one way of ending.
  initial begin : byte_source
    string      opening;
    logic [7:0] b;
    in_bus.valid      <= 1'b0;
    in_bus.text_byte  <= '0;
    in_bus.final_byte <= 1'b0;
    rst_n             <= 1'b0;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;

    // Character extremes, every blank, a comment, and tokens closed by the next token.
    opening = "Az_09 .Z9\t#q\n9a.z\013\014\0150";
    for (int i = 0; i < opening.len(); i++) push_byte(opening[i], 1'b0);

    // Well-formed tokens with random content, sometimes packed with no blank between.
    while (bytes_sent < 340) begin
      if ($urandom_range(0, 7) == 0) in_gap_max = ($urandom_range(0, 2) == 0) ? 0 : 3;
      case ($urandom_range(0, 5))
        0, 5: begin
          push_byte(pick_letter(), 1'b0);
          repeat ($urandom_range(0, 5)) push_byte(pick_alnum(1'b1), 1'b0);
        end
        1: repeat ($urandom_range(1, 5)) push_byte(pick_digit(), 1'b0);
        2: begin
          push_byte(ast_pkg::CHAR_DOT, 1'b0);
          repeat ($urandom_range(0, 5)) push_byte(pick_alnum(1'b0), 1'b0);
        end
        3: begin
          // Comment bodies carry any byte but a line feed, high bytes included.
          push_byte(ast_pkg::CHAR_HASH, 1'b0);
          repeat ($urandom_range(0, 6)) begin
            b = 8'($urandom_range(0, 255));
            if (b == ast_pkg::CHAR_LF) b = 8'hFF;
            push_byte(b, 1'b0);
          end
          push_byte(ast_pkg::CHAR_LF, 1'b0);
        end
        default: repeat ($urandom_range(1, 3)) push_byte(BLANK_SET[$urandom_range(0, 5)], 1'b0);
      endcase
      if ($urandom_range(0, 3) != 0) push_byte(BLANK_SET[$urandom_range(0, 5)], 1'b0);
    end

    push_byte(ast_pkg::CHAR_SPACE, 1'b0);
    push_byte("7", 1'b0);

    // End the stream with an open number, in one of four ways.
    in_gap_max = 3;
    case ($urandom_range(0, 3))
      0: push_byte("8", 1'b1);
      1: begin
        case ($urandom_range(0, 3))
          0:       b = 8'h00;
          1:       b = "!";
          2:       b = ast_pkg::CHAR_UNDERSCORE;
          default: b = 8'h80;
        endcase
        push_byte(b, 1'b0);
      end
      2: push_byte("~", 1'b1);
      default: push_byte("x", 1'b1);
    endcase

    // Bytes after the end token must give nothing.
    push_byte(8'hFF, 1'b1);
    push_byte(8'h00, 1'b0);
    repeat (30) push_byte(8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
    in_bus.valid <= 1'b0;

    while (sb.outstanding() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    if (sb.mismatches == 0 && sb.outstanding() == 0) begin
      $display("assembler_source_tokenizer: match");
    end else begin
      $display("assembler_source_tokenizer: mismatch");
    end
    $finish;
  end

  // Watchdog well beyond the slowest legal run.
  initial begin : watchdog
    #500_000;
    $display("assembler_source_tokenizer: mismatch");
    $finish;
  end

endmodule
